// ----- design/mdfs_pkg.sv -----
// Shared types, codes and reset values for the motor drive fault supervisor.
`default_nettype none

package mdfs_pkg;

  // System mode codes
  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_RUNNING = 2'd1;
  localparam logic [1:0] MODE_FAULT   = 2'd2;

  // Fault codes
  localparam logic [2:0] CODE_NONE         = 3'd0;
  localparam logic [2:0] CODE_ADC          = 3'd1;
  localparam logic [2:0] CODE_ENCODER      = 3'd2;
  localparam logic [2:0] CODE_UNDERVOLTAGE = 3'd3;
  localparam logic [2:0] CODE_INIT_FAILED  = 3'd4;

  // Init diagnostic result codes
  localparam logic [1:0] DIAG_NOT_EXECUTED = 2'd0;
  localparam logic [1:0] DIAG_SUCCESS      = 2'd1;
  localparam logic [1:0] DIAG_FAILED       = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_FAULT_THRESHOLD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNDERVOLTAGE_ENABLE    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_CHECKS        = 8'd2;

  // Configuration reset values
  localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
  localparam logic        UV_ENABLE_RESET = 1'b1;
  localparam logic [15:0] REQUIRED_RESET  = 16'h007F;

  localparam logic [15:0] INVALID_MAX = 16'hFFFF;
  localparam logic [31:0] SKIP_MAX    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  sensor_fault_threshold;
    logic        undervoltage_enable;
    logic [15:0] required_checks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  fault;
    logic [1:0]  diag;
    logic [15:0] seen_mask;
    logic [15:0] failed_mask;
    logic [15:0] invalid_count;
    logic [31:0] skip_count;
  } supv_state_t;

  typedef struct packed {
    logic [15:0] pass_bits;
    logic [15:0] fail_bits;
    logic        sensor_updated;
    logic        adc_ok;
    logic        encoder_ok;
    logic        loop_skipped;
    logic        undervoltage;
    logic        finalize;
  } item_t;

  typedef struct packed {
    logic [1:0]  system_mode;
    logic [2:0]  fault_code;
    logic [1:0]  init_result;
    logic [31:0] skip_total;
    logic [15:0] invalid_run;
    logic [15:0] missing_checks;
    logic        fault_entered;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mdfs_cfg_regs.sv -----
// Configuration register bank for the motor drive fault supervisor.
`default_nettype none

module mdfs_cfg_regs
  import mdfs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_fault_threshold <= THRESHOLD_RESET;
      cfg.undervoltage_enable    <= UV_ENABLE_RESET;
      cfg.required_checks        <= REQUIRED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENSOR_FAULT_THRESHOLD: cfg.sensor_fault_threshold <= cfg_data[7:0];
        REG_UNDERVOLTAGE_ENABLE:    cfg.undervoltage_enable    <= cfg_data[0];
        REG_REQUIRED_CHECKS:        cfg.required_checks        <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/mdfs_step.sv -----
// Combinational state update and result for one signal bundle.
`default_nettype none

module mdfs_step
  import mdfs_pkg::*;
(
  input  wire supv_state_t state,
  input  wire cfg_t        cfg,
  input  wire item_t       item,
  output supv_state_t      state_next,
  output result_t          result
);

  always_comb begin
    logic [1:0]  mode;
    logic [2:0]  fault;
    logic [1:0]  diag;
    logic [15:0] seen;
    logic [15:0] failed;
    logic [15:0] inv;
    logic [15:0] missing;
    logic        bad_read;
    logic        uv_trip;
    logic [1:0]  skip_inc;
    logic [32:0] skip_sum;
    logic [31:0] skip;

    mode   = state.mode;
    fault  = state.fault;
    diag   = state.diag;
    inv    = state.invalid_count;
    seen   = state.seen_mask | item.pass_bits | item.fail_bits;
    failed = state.failed_mask | item.fail_bits;

    bad_read = item.sensor_updated && !(item.adc_ok && item.encoder_ok);
    uv_trip  = item.undervoltage && cfg.undervoltage_enable;

    if (item.sensor_updated) begin
      if (item.adc_ok && item.encoder_ok) begin
        inv = '0;
        if (mode != MODE_FAULT) begin
          fault = CODE_NONE;
        end
      end else begin
        if (inv != INVALID_MAX) begin
          inv = inv + 16'd1;
        end
        fault = item.adc_ok ? CODE_ENCODER : CODE_ADC;
        if (inv >= {8'd0, cfg.sensor_fault_threshold}) begin
          mode = MODE_FAULT;
        end
      end
    end

    if (uv_trip) begin
      mode  = MODE_FAULT;
      fault = CODE_UNDERVOLTAGE;
    end

    // Up to three skipped steps per bundle, saturating as a whole
    skip_inc = {1'b0, bad_read} + {1'b0, item.loop_skipped} + {1'b0, uv_trip};
    skip_sum = {1'b0, state.skip_count} + {31'd0, skip_inc};
    skip     = skip_sum[32] ? SKIP_MAX : skip_sum[31:0];

    missing = cfg.required_checks & ~seen;

    if (item.finalize) begin
      if (seen == 16'd0) begin
        diag  = DIAG_NOT_EXECUTED;
        mode  = MODE_FAULT;
        fault = CODE_INIT_FAILED;
      end else if (failed == 16'd0 && missing == 16'd0) begin
        diag  = DIAG_SUCCESS;
        mode  = MODE_RUNNING;
        fault = CODE_NONE;
      end else begin
        diag  = DIAG_FAILED;
        mode  = MODE_FAULT;
        fault = CODE_INIT_FAILED;
      end
    end

    state_next.mode          = mode;
    state_next.fault         = fault;
    state_next.diag          = diag;
    state_next.seen_mask     = seen;
    state_next.failed_mask   = failed;
    state_next.invalid_count = inv;
    state_next.skip_count    = skip;

    result.system_mode    = mode;
    result.fault_code     = fault;
    result.init_result    = diag;
    result.skip_total     = skip;
    result.invalid_run    = inv;
    result.missing_checks = missing;
    result.fault_entered  = (state.mode != MODE_FAULT) && (mode == MODE_FAULT);
  end

endmodule

`default_nettype wire

// ----- design/motor_drive_fault_supervisor_unit.sv -----
// Top level of the motor drive fault supervisor: input register, step logic, result register.
// An accepted request waits in the input register until the result slot is free or drained.
// One request per cycle while the consumer takes results; the input and result registers
//   each hold one request, and the supervisor state advances as a request moves between them.
// Reset (rst, synchronous, active high): all supervisor state clears to zero (init mode),
//   configuration returns to threshold 3, undervoltage enabled, required checks 0x007F.
`default_nettype none

module motor_drive_fault_supervisor_unit
  import mdfs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  // Request channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [15:0]            pass_bits,
  input  wire logic [15:0]            fail_bits,
  input  wire logic                   sensor_updated,
  input  wire logic                   adc_ok,
  input  wire logic                   encoder_ok,
  input  wire logic                   loop_skipped,
  input  wire logic                   undervoltage,
  input  wire logic                   finalize,

  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  system_mode,
  output logic [2:0]                  fault_code,
  output logic [1:0]                  init_result,
  output logic [31:0]                 skip_total,
  output logic [15:0]                 invalid_run,
  output logic [15:0]                 missing_checks,
  output logic                        fault_entered,

  // Configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  supv_state_t state;
  supv_state_t state_next;
  item_t       item;
  result_t     result;
  result_t     result_q;
  logic        item_valid;
  logic        advance;

  mdfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held request into the result register when that slot is free
  // or being drained this cycle; the state update happens on the same edge.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register: valid bit under reset, payload loads on acceptance only
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.pass_bits      <= pass_bits;
      item.fail_bits      <= fail_bits;
      item.sensor_updated <= sensor_updated;
      item.adc_ok         <= adc_ok;
      item.encoder_ok     <= encoder_ok;
      item.loop_skipped   <= loop_skipped;
      item.undervoltage   <= undervoltage;
      item.finalize       <= finalize;
    end
  end

  mdfs_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // Supervisor state: commit the step's update as the request advances
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign system_mode    = result_q.system_mode;
  assign fault_code     = result_q.fault_code;
  assign init_result    = result_q.init_result;
  assign skip_total     = result_q.skip_total;
  assign invalid_run    = result_q.invalid_run;
  assign missing_checks = result_q.missing_checks;
  assign fault_entered  = result_q.fault_entered;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the motor drive fault supervisor unit.
`default_nettype none

module testbench;
  import mdfs_pkg::*;

  // Flag bits of a request, in the order of the item fields after the two masks
  localparam logic [5:0] SIG_UPD  = 6'b100000;
  localparam logic [5:0] SIG_ADC  = 6'b010000;
  localparam logic [5:0] SIG_ENC  = 6'b001000;
  localparam logic [5:0] SIG_SKIP = 6'b000100;
  localparam logic [5:0] SIG_UV   = 6'b000010;
  localparam logic [5:0] SIG_FIN  = 6'b000001;

  localparam int RUN_READS = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid       = 1'b0;
  logic                   in_ready;
  logic [15:0]            pass_bits      = '0;
  logic [15:0]            fail_bits      = '0;
  logic                   sensor_updated = 1'b0;
  logic                   adc_ok         = 1'b0;
  logic                   encoder_ok     = 1'b0;
  logic                   loop_skipped   = 1'b0;
  logic                   undervoltage   = 1'b0;
  logic                   finalize       = 1'b0;

  logic                   out_valid;
  logic                   out_ready      = 1'b0;
  logic [1:0]             system_mode;
  logic [2:0]             fault_code;
  logic [1:0]             init_result;
  logic [31:0]            skip_total;
  logic [15:0]            invalid_run;
  logic [15:0]            missing_checks;
  logic                   fault_entered;

  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [CFG_DATA_W-1:0]  cfg_data       = '0;

  motor_drive_fault_supervisor_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pass_bits      (pass_bits),
    .fail_bits      (fail_bits),
    .sensor_updated (sensor_updated),
    .adc_ok         (adc_ok),
    .encoder_ok     (encoder_ok),
    .loop_skipped   (loop_skipped),
    .undervoltage   (undervoltage),
    .finalize       (finalize),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .system_mode    (system_mode),
    .fault_code     (fault_code),
    .init_result    (init_result),
    .skip_total     (skip_total),
    .invalid_run    (invalid_run),
    .missing_checks (missing_checks),
    .fault_entered  (fault_entered),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Requests waiting to be driven, and supervisor results still owed by the block
  item_t       pending_requests[$];
  result_t     expected_results[$];

  // Shadow copy of the supervisor: configuration and state
  cfg_t        mirror_cfg;
  supv_state_t mirror_state;

  int requests_queued   = 0;
  int requests_launched = 0;
  int requests_accepted = 0;
  int results_seen      = 0;
  int results_checked   = 0;
  int mismatches        = 0;
  int reg_writes        = 0;
  int fault_entries     = 0;
  int gradings          = 0;
  int longest_run       = 0;

  // Idling: style 0 never waits, 1 waits now and then, 2 waits on most requests
  bit idle_on     = 1'b1;
  int send_style  = 0;
  int recv_style  = 0;
  int send_gap    = 0;
  int recv_gap    = 0;
  int bad_reads_left = 0;
  item_t   req_now;
  result_t got;
  result_t want;

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop: well past the slowest legal run
  initial begin
    #12000000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int draw_wait(input int style);
    if (!idle_on || style == 0) return 0;
    if (style == 1 && $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void skip_bump();
    if (mirror_state.skip_count != SKIP_MAX)
      mirror_state.skip_count = mirror_state.skip_count + 32'd1;
  endfunction

  // Advance the shadow supervisor by one request and return what the block must show.
  // Update order: masks, sensor read, skipped step, undervoltage, grading.
  function automatic result_t supervise_step(input item_t req);
    result_t res;
    logic    was_fault;
    logic [15:0] missing;
    was_fault = (mirror_state.mode == MODE_FAULT);

    mirror_state.seen_mask   = mirror_state.seen_mask | req.pass_bits | req.fail_bits;
    mirror_state.failed_mask = mirror_state.failed_mask | req.fail_bits;

    if (req.sensor_updated) begin
      if (req.adc_ok && req.encoder_ok) begin
        // A good read ends the run; the fault code only clears outside fault
        mirror_state.invalid_count = '0;
        if (mirror_state.mode != MODE_FAULT) mirror_state.fault = CODE_NONE;
      end else begin
        skip_bump();
        if (mirror_state.invalid_count != INVALID_MAX)
          mirror_state.invalid_count = mirror_state.invalid_count + 16'd1;
        mirror_state.fault = req.adc_ok ? CODE_ENCODER : CODE_ADC;
        if (mirror_state.invalid_count >= {8'd0, mirror_cfg.sensor_fault_threshold})
          mirror_state.mode = MODE_FAULT;
      end
    end

    if (req.loop_skipped) skip_bump();

    if (req.undervoltage && mirror_cfg.undervoltage_enable) begin
      mirror_state.mode  = MODE_FAULT;
      mirror_state.fault = CODE_UNDERVOLTAGE;
      skip_bump();
    end

    if (req.finalize) begin
      missing = mirror_cfg.required_checks & ~mirror_state.seen_mask;
      if (mirror_state.seen_mask == '0) begin
        mirror_state.diag  = DIAG_NOT_EXECUTED;
        mirror_state.mode  = MODE_FAULT;
        mirror_state.fault = CODE_INIT_FAILED;
      end else if (mirror_state.failed_mask == '0 && missing == '0) begin
        mirror_state.diag  = DIAG_SUCCESS;
        mirror_state.mode  = MODE_RUNNING;
        mirror_state.fault = CODE_NONE;
      end else begin
        mirror_state.diag  = DIAG_FAILED;
        mirror_state.mode  = MODE_FAULT;
        mirror_state.fault = CODE_INIT_FAILED;
      end
    end

    res.system_mode    = mirror_state.mode;
    res.fault_code     = mirror_state.fault;
    res.init_result    = mirror_state.diag;
    res.skip_total     = mirror_state.skip_count;
    res.invalid_run    = mirror_state.invalid_count;
    res.missing_checks = mirror_cfg.required_checks & ~mirror_state.seen_mask;
    res.fault_entered  = !was_fault && (mirror_state.mode == MODE_FAULT);
    return res;
  endfunction

  function automatic void note_field(input string field, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_checked, field, exp_v, act_v);
    end
  endfunction

  // Driver: hold a request until it is taken, then idle for the drawn gap
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(supervise_step(req_now));
        requests_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req_now = pending_requests.pop_front();
          pass_bits      <= req_now.pass_bits;
          fail_bits      <= req_now.fail_bits;
          sensor_updated <= req_now.sensor_updated;
          adc_ok         <= req_now.adc_ok;
          encoder_ok     <= req_now.encoder_ok;
          loop_skipped   <= req_now.loop_skipped;
          undervoltage   <= req_now.undervoltage;
          finalize       <= req_now.finalize;
          in_valid       <= 1'b1;
          if (requests_launched % 40 == 0) send_style = $urandom_range(0, 2);
          send_gap = draw_wait(send_style);
          requests_launched++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results, check them against the oldest prediction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {system_mode, fault_code, init_result, skip_total, invalid_run,
               missing_checks, fault_entered};
        if (got.invalid_run > longest_run) longest_run = got.invalid_run;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request outstanding: %h", got);
        end else begin
          want = expected_results.pop_front();
          note_field("system_mode",    want.system_mode,    got.system_mode);
          note_field("fault_code",     want.fault_code,     got.fault_code);
          note_field("init_result",    want.init_result,    got.init_result);
          note_field("skip_total",     want.skip_total,     got.skip_total);
          note_field("invalid_run",    want.invalid_run,    got.invalid_run);
          note_field("missing_checks", want.missing_checks, got.missing_checks);
          note_field("fault_entered",  want.fault_entered,  got.fault_entered);
          if (want.fault_entered) fault_entries++;
          results_checked++;
        end
        results_seen++;
        if (results_seen % 40 == 0) recv_style = $urandom_range(0, 2);
        recv_gap = draw_wait(recv_style);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic enqueue(input item_t req);
    pending_requests.push_back(req);
    requests_queued++;
    if (req.finalize) gradings++;
  endtask

  // Drain: every queued request has produced its checked result
  task automatic settle();
    while (results_checked != requests_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SENSOR_FAULT_THRESHOLD: mirror_cfg.sensor_fault_threshold = val[7:0];
      REG_UNDERVOLTAGE_ENABLE:    mirror_cfg.undervoltage_enable    = val[0];
      REG_REQUIRED_CHECKS:        mirror_cfg.required_checks        = val[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [7:0] thr, input logic uv_en, input logic [15:0] req);
    write_reg(REG_SENSOR_FAULT_THRESHOLD, {8'd0, thr});
    write_reg(REG_UNDERVOLTAGE_ENABLE, {15'd0, uv_en});
    write_reg(REG_REQUIRED_CHECKS, req);
  endtask

  // Random drive traffic: mostly plausible bundles with bursts of bad sensor reads,
  // a little pure noise. Fail bits stay off unless allowed, since they stick for good.
  task automatic run_random(input int count, input bit allow_fail);
    item_t req;
    int    n;
    int    burst_cap;
    for (n = 0; n < count; n++) begin
      req = '0;
      if ($urandom_range(0, 99) < 6) begin
        req.pass_bits = 16'($urandom);
        req.fail_bits = allow_fail ? 16'($urandom) : 16'h0000;
        {req.sensor_updated, req.adc_ok, req.encoder_ok, req.loop_skipped,
         req.undervoltage, req.finalize} = 6'($urandom);
      end else begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: req.pass_bits = 16'h0000;
          4, 5:       req.pass_bits = 16'h0001 << $urandom_range(0, 15);
          6:          req.pass_bits = mirror_cfg.required_checks;
          default:    req.pass_bits = 16'($urandom);
        endcase
        if (allow_fail && $urandom_range(0, 9) == 0)
          req.fail_bits = 16'h0001 << $urandom_range(0, 15);
        req.loop_skipped = ($urandom_range(0, 4) == 0);
        req.undervoltage = ($urandom_range(0, 24) == 0);
        req.finalize     = ($urandom_range(0, 14) == 0);
        // Start a run of bad reads, usually short, sometimes past the threshold
        if (bad_reads_left == 0 && $urandom_range(0, 11) == 0) begin
          burst_cap = mirror_cfg.sensor_fault_threshold + 2;
          if (burst_cap > 40 && $urandom_range(0, 3) != 0) burst_cap = 40;
          bad_reads_left = $urandom_range(1, burst_cap);
        end
        if (bad_reads_left > 0) begin
          bad_reads_left--;
          req.sensor_updated = 1'b1;
          case ($urandom_range(0, 2))
            0:       {req.adc_ok, req.encoder_ok} = 2'b00;
            1:       {req.adc_ok, req.encoder_ok} = 2'b01;
            default: {req.adc_ok, req.encoder_ok} = 2'b10;
          endcase
        end else begin
          req.sensor_updated = ($urandom_range(0, 9) < 7);
          if (req.sensor_updated) {req.adc_ok, req.encoder_ok} = 2'b11;
          else {req.adc_ok, req.encoder_ok} = 2'($urandom);
        end
      end
      enqueue(req);
    end
  endtask

  initial begin
    int i;
    mirror_cfg.sensor_fault_threshold = THRESHOLD_RESET;
    mirror_cfg.undervoltage_enable    = UV_ENABLE_RESET;
    mirror_cfg.required_checks        = REQUIRED_RESET;
    mirror_state = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Walk the reset configuration through grading, sensor runs and trips
    enqueue({16'h0000, 16'h0000, 6'b000000});
    enqueue({16'h0000, 16'h0000, SIG_FIN});                   // grade with nothing seen
    enqueue({16'h007F, 16'h0000, SIG_FIN});                   // good grading leaves fault
    enqueue({16'h0001, 16'h0000, SIG_UPD});                   // adc bad
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ADC});         // encoder bad
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ENC});         // run meets threshold
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ADC | SIG_ENC}); // good read keeps code
    enqueue({16'h0000, 16'h0000, SIG_SKIP});
    enqueue({16'h0000, 16'h0000, SIG_UV});
    enqueue({16'h8000, 16'h0000, SIG_FIN});
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ADC | SIG_ENC}); // code clears when running
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_SKIP | SIG_UV}); // three skips at once
    enqueue({16'h0000, 16'h0000, SIG_FIN});
    settle();

    // Low threshold, undervoltage ignored, every check required
    set_config(8'd1, 1'b0, 16'hFFFF);
    enqueue({16'h0000, 16'h0000, SIG_UV});
    run_random(250, 1'b0);
    settle();

    set_config(8'd255, 1'b1, 16'h0000);
    run_random(250, 1'b0);
    settle();

    // Threshold zero: any bad read trips
    set_config(8'd0, 1'b1, 16'h007F);
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ADC | SIG_ENC});
    enqueue({16'hFFFF, 16'h0000, SIG_FIN});
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ENC});
    run_random(250, 1'b0);
    settle();

    set_config(8'($urandom_range(2, 8)), 1'($urandom), 16'($urandom));
    run_random(250, 1'b0);
    settle();

    set_config(8'd3, 1'b0, 16'h8001);
    run_random(250, 1'b0);
    settle();

    // Long run of bad reads at full rate, past a high threshold, then clear it
    set_config(8'd100, 1'b1, 16'hFFFF);
    idle_on = 1'b0;
    enqueue({16'hFFFF, 16'h0000, SIG_FIN});
    for (i = 0; i < RUN_READS; i++)
      enqueue({16'h0000, 16'h0000, (i % 2 == 1) ? (SIG_UPD | SIG_ADC) : SIG_UPD});
    enqueue({16'h0000, 16'h0000, SIG_UPD | SIG_ADC | SIG_ENC});
    settle();
    idle_on = 1'b1;

    // Failed checks last: they stick and fail every later grading
    set_config(8'($urandom_range(1, 6)), 1'b1, 16'h007F);
    enqueue({16'h0000, 16'h8000, SIG_FIN});
    enqueue({16'hFFFF, 16'hFFFF, 6'b111111});
    enqueue({16'h0001, 16'h0000, SIG_FIN});
    run_random(250, 1'b1);
    settle();
    repeat (4) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_results.size());
    end
    $display("covered %0d requests and %0d register writes; %0d results checked",
             requests_accepted, reg_writes, results_checked);
    $display("%0d gradings, %0d fault entries, longest invalid run %0d",
             gradings, fault_entries, longest_run);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
